>>> src/fpvm_pkg.sv
// ----------------------------------------------------------------------------
// fpvm_pkg
// Shared types and constants of the pulse flow meter: transaction payloads,
// the job that passes from front to back, the divider request and response,
// register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fpvm_pkg;

	// Register indexes of the configuration port.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd1;

	localparam int unsigned CFG_W = 16;
	localparam logic [CFG_W-1:0] CALIBRATION_RESET = 16'd1920;
	localparam logic [CFG_W-1:0] WINDOW_RESET      = 16'd1000;

	// Default depth of the job queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Fixed-point scale factors.
	localparam logic [24:0] RATE_SCALE   = 25'd25600000;
	localparam logic [17:0] VOLUME_SCALE = 18'd256000;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

	localparam logic [13:0] RATE_MAX   = 14'd12000;
	localparam logic [26:0] VOLUME_MAX = 27'd100000000;

	// Divider geometry. A quotient of N bits takes N+1 steps; the extra leading
	// step flags quotients of 2^N and above, which always saturate.
	localparam int unsigned DIV_W  = 64;
	localparam int unsigned QUO_W  = 28;
	localparam int unsigned STEP_W = 5;
	localparam int unsigned RATE_QBITS   = 15;
	localparam int unsigned VOLUME_QBITS = 27;
	localparam logic [STEP_W-1:0] RATE_STEPS   = STEP_W'(RATE_QBITS + 1);
	localparam logic [STEP_W-1:0] VOLUME_STEPS = STEP_W'(VOLUME_QBITS + 1);

	typedef struct packed {
		logic [3:0] edges;
		logic [7:0] elapsed_increment_ms;
		logic       clear_volume;
	} in_t;

	typedef struct packed {
		logic [13:0] rate_centi_lpm;
		logic        rate_valid;
		logic        rate_updated;
		logic [26:0] volume_ml;
	} out_t;

	typedef struct packed {
		logic [31:0] window_pulses;
		logic [31:0] window_ms;
		logic [31:0] volume_pulses;
		logic        updated;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> src/fpvm_front.sv
// ----------------------------------------------------------------------------
// fpvm_front
// Accepts input transactions, advances the pulse and millisecond counters,
// decides whether the window closes and queues a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpvm_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire fpvm_pkg::in_t            in_data,
	input  wire logic                     queue_full,
	input  wire logic [fpvm_pkg::CFG_W-1:0] window_ms,
	output logic                          push,
	output fpvm_pkg::job_t                job
);

	logic [31:0] pulse_total_q;
	logic [31:0] time_now_q;
	logic [31:0] win_start_ms_q;
	logic [31:0] win_start_pulses_q;
	logic [31:0] vol_base_q;

	logic [31:0] pulse_next;
	logic [31:0] time_next;
	logic [31:0] base_next;
	logic [31:0] elapsed;
	logic        closes;

	assign push = in_valid && !queue_full;

	always_comb begin
		pulse_next = pulse_total_q + 32'(in_data.edges);
		time_next  = time_now_q + 32'(in_data.elapsed_increment_ms);
		base_next  = in_data.clear_volume ? pulse_next : vol_base_q;
		elapsed    = time_next - win_start_ms_q;
		closes     = elapsed >= 32'(window_ms);

		job.window_pulses = pulse_next - win_start_pulses_q;
		job.window_ms     = elapsed;
		job.volume_pulses = pulse_next - base_next;
		job.updated       = closes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_total_q      <= '0;
			time_now_q         <= '0;
			win_start_ms_q     <= '0;
			win_start_pulses_q <= '0;
			vol_base_q         <= '0;
		end else if (push) begin
			pulse_total_q <= pulse_next;
			time_now_q    <= time_next;
			vol_base_q    <= base_next;
			if (closes) begin
				win_start_ms_q     <= time_next;
				win_start_pulses_q <= pulse_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/fpvm_fifo.sv
// ----------------------------------------------------------------------------
// fpvm_fifo
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpvm_fifo #(
	parameter int unsigned DEPTH = fpvm_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fpvm_pkg::job_t push_data,
	input  wire logic           pop,
	output fpvm_pkg::job_t      head,
	output logic                full,
	output logic                empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	fpvm_pkg::job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/fpvm_div.sv
// ----------------------------------------------------------------------------
// fpvm_div
// Restoring divider, one quotient bit per cycle. The caller hands in the
// divisor already aligned to the top quotient bit and the number of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fpvm_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpvm_pkg::div_req_t req,
	output fpvm_pkg::div_rsp_t      rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [fpvm_pkg::STEP_W-1:0]   cnt_q;
	logic [fpvm_pkg::DIV_W-1:0]    rem_q;
	logic [fpvm_pkg::DIV_W-1:0]    dsr_q;
	logic [fpvm_pkg::QUO_W-1:0]    quo_q;
	logic                          fits;

	assign fits     = rem_q >= dsr_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsr_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[fpvm_pkg::QUO_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fpvm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/fpvm_back.sv
// ----------------------------------------------------------------------------
// fpvm_back
// Takes jobs from the queue, forms the volume and, on a closed window, rate
// quotients on the shared divider, saturates them and presents the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpvm_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       queue_empty,
	input  wire fpvm_pkg::job_t             head,
	output logic                            pop,
	input  wire logic [fpvm_pkg::CFG_W-1:0] calibration_q8,
	output fpvm_pkg::div_req_t              div_req,
	input  wire fpvm_pkg::div_rsp_t         div_rsp,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output fpvm_pkg::out_t                  out_data
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RNUM = 8'b0000_0010,
		ST_RDEN = 8'b0000_0100,
		ST_RDIV = 8'b0000_1000,
		ST_VNUM = 8'b0001_0000,
		ST_VDEN = 8'b0010_0000,
		ST_VDIV = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	fpvm_pkg::job_t                 job_q;
	logic [fpvm_pkg::DIV_W-1:0]     num_q;
	logic [13:0]                    rate_hold_q;
	logic                           rate_seen_q;
	logic [26:0]                    vol_q;
	logic                           out_valid_q;
	fpvm_pkg::out_t                 out_data_q;

	logic                           out_free;
	logic [56:0]                    rate_num;
	logic [47:0]                    rate_den;
	logic [49:0]                    vol_num;
	logic [21:0]                    vol_den;
	logic [13:0]                    rate_sat;
	logic [26:0]                    vol_sat;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		rate_num = 57'(job_q.window_pulses) * 57'(fpvm_pkg::RATE_SCALE);
		rate_den = 48'(job_q.window_ms) * 48'(calibration_q8);
		vol_num  = 50'(job_q.volume_pulses) * 50'(fpvm_pkg::VOLUME_SCALE);
		vol_den  = 22'(calibration_q8) * 22'(fpvm_pkg::SEC_PER_MIN);

		rate_sat = (div_rsp.quo > fpvm_pkg::QUO_W'(fpvm_pkg::RATE_MAX))
			? fpvm_pkg::RATE_MAX : div_rsp.quo[13:0];
		vol_sat  = (div_rsp.quo > fpvm_pkg::QUO_W'(fpvm_pkg::VOLUME_MAX))
			? fpvm_pkg::VOLUME_MAX : div_rsp.quo[26:0];
	end

	always_comb begin
		state_d         = state_q;
		pop             = 1'b0;
		div_req.start   = 1'b0;
		div_req.steps   = fpvm_pkg::VOLUME_STEPS;
		div_req.num     = num_q;
		div_req.den     = fpvm_pkg::DIV_W'(vol_den) << fpvm_pkg::VOLUME_QBITS;
		unique case (state_q)
			ST_IDLE: begin
				if (!queue_empty) begin
					pop     = 1'b1;
					state_d = head.updated ? ST_RNUM : ST_VNUM;
				end
			end
			ST_RNUM: state_d = ST_RDEN;
			ST_RDEN: begin
				div_req.start = 1'b1;
				div_req.steps = fpvm_pkg::RATE_STEPS;
				div_req.den   = fpvm_pkg::DIV_W'(rate_den) << fpvm_pkg::RATE_QBITS;
				state_d       = ST_RDIV;
			end
			ST_RDIV: begin
				if (div_rsp.done) begin
					state_d = ST_VNUM;
				end
			end
			ST_VNUM: state_d = ST_VDEN;
			ST_VDEN: begin
				div_req.start = 1'b1;
				state_d       = ST_VDIV;
			end
			ST_VDIV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == ST_RNUM) begin
			num_q <= fpvm_pkg::DIV_W'(rate_num);
		end else if (state_q == ST_VNUM) begin
			num_q <= fpvm_pkg::DIV_W'(vol_num);
		end
		if (state_q == ST_VDIV && div_rsp.done) begin
			vol_q <= vol_sat;
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q.rate_centi_lpm <= rate_hold_q;
			out_data_q.rate_valid     <= rate_seen_q;
			out_data_q.rate_updated   <= job_q.updated;
			out_data_q.volume_ml      <= vol_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_hold_q <= '0;
			rate_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RDIV && div_rsp.done) begin
				rate_hold_q <= rate_sat;
				rate_seen_q <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= state_q == ST_OUT;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/flow_pulse_rate_volume_meter.sv
// ----------------------------------------------------------------------------
// flow_pulse_rate_volume_meter
// Pulse flow meter: running pulse and millisecond counts, a windowed rate in
// 0.01 L/min and the volume since the last clear in mL.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. The front end
// updates the counters in the cycle a transaction is accepted and queues a job;
// the back end works it out on one shared restoring divider that produces a
// quotient bit per cycle. A window-closing transaction runs a rate division
// (16 steps), then a volume division (28 steps); any other runs only the
// volume division. The queue of QUEUE_DEPTH jobs (2 by default) and the output
// register let input keep arriving while a result waits to be taken.
// Configuration registers must be written only while no transaction is in
// flight; the block does not enforce this. A write of zero is ignored.
`default_nettype none

module flow_pulse_rate_volume_meter #(
	parameter int unsigned QUEUE_DEPTH = fpvm_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fpvm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fpvm_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire fpvm_pkg::in_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output fpvm_pkg::out_t                      out_data
);

	logic [fpvm_pkg::CFG_W-1:0] calibration_q;
	logic [fpvm_pkg::CFG_W-1:0] window_q;

	logic               push;
	logic               pop;
	logic               queue_full;
	logic               queue_empty;
	fpvm_pkg::job_t     push_job;
	fpvm_pkg::job_t     head_job;
	fpvm_pkg::div_req_t div_req;
	fpvm_pkg::div_rsp_t div_rsp;

	assign in_stall = queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibration_q <= fpvm_pkg::CALIBRATION_RESET;
			window_q      <= fpvm_pkg::WINDOW_RESET;
		end else if (cfg_we && cfg_data != '0) begin
			unique case (cfg_index)
				fpvm_pkg::REG_CALIBRATION: calibration_q <= cfg_data;
				fpvm_pkg::REG_WINDOW:      window_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	fpvm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.queue_full (queue_full),
		.window_ms  (window_q),
		.push       (push),
		.job        (push_job)
	);

	fpvm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.head      (head_job),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	fpvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fpvm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_empty    (queue_empty),
		.head           (head_job),
		.pop            (pop),
		.calibration_q8 (calibration_q),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

	// The rate and volume never leave their saturated ranges.
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rate_centi_lpm <= fpvm_pkg::RATE_MAX)
		else $error("rate above saturation limit");

	a_volume_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.volume_ml <= fpvm_pkg::VOLUME_MAX)
		else $error("volume above saturation limit");

	// A closed window always leaves a valid rate behind it.
	a_update_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rate_updated |-> out_data.rate_valid)
		else $error("rate update without rate valid");

	// Before the first window closes the rate reads as zero.
	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rate_valid |-> out_data.rate_centi_lpm == '0)
		else $error("nonzero rate before first window");

	// The divider is never started back to back.
	a_div_single: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_req.start)
		else $error("divider restarted back to back");

endmodule

`default_nettype wire
